>>> design/i2cdw_pkg.sv
// ----------------------------------------------------------------------------
// i2cdw_pkg
// Shared types and constants of the display write engine.
// ----------------------------------------------------------------------------
package i2cdw_pkg;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_PHASE_TICKS = 2'd0;
    localparam logic [1:0] REG_DEV_ADDR    = 2'd1;
    localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

    // register reset values
    localparam logic [15:0] RST_PHASE_TICKS = 16'd72;
    localparam logic [7:0]  RST_DEV_ADDR    = 8'h78;
    localparam logic [7:0]  RST_ACK_TIMEOUT = 8'd250;

    // control byte per operation kind
    localparam logic [7:0] CTRL_CMD  = 8'h00;
    localparam logic [7:0] CTRL_DATA = 8'h40;

    // one input item
    typedef struct packed {
        logic       request;
        logic       op;
        logic [7:0] payload;
        logic       sda_in;
    } item_t;

    // register file contents seen by the engine
    typedef struct packed {
        logic [15:0] phase_ticks;
        logic [7:0]  device_address;
        logic [7:0]  ack_timeout;
    } cfg_t;

endpackage

>>> design/i2cdw_regs.sv
// ----------------------------------------------------------------------------
// i2cdw_regs
// APB register file: phase length, device address and ack timeout.
// ----------------------------------------------------------------------------
module i2cdw_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cdw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [i2cdw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [i2cdw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready,
    output i2cdw_pkg::cfg_t                    cfg
);

    i2cdw_pkg::cfg_t cfg_reg;
    logic            wr_en;
    logic [1:0]      reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks    <= i2cdw_pkg::RST_PHASE_TICKS;
            cfg_reg.device_address <= i2cdw_pkg::RST_DEV_ADDR;
            cfg_reg.ack_timeout    <= i2cdw_pkg::RST_ACK_TIMEOUT;
        end else if (wr_en) begin
            unique case (reg_idx)
                i2cdw_pkg::REG_PHASE_TICKS: cfg_reg.phase_ticks    <= pwdata[15:0];
                i2cdw_pkg::REG_DEV_ADDR:    cfg_reg.device_address <= pwdata[7:0];
                i2cdw_pkg::REG_ACK_TIMEOUT: cfg_reg.ack_timeout    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            i2cdw_pkg::REG_PHASE_TICKS: prdata = {16'd0, cfg_reg.phase_ticks};
            i2cdw_pkg::REG_DEV_ADDR:    prdata = {24'd0, cfg_reg.device_address};
            i2cdw_pkg::REG_ACK_TIMEOUT: prdata = {24'd0, cfg_reg.ack_timeout};
            default:                    prdata = '0;
        endcase
    end

endmodule

>>> design/i2cdw_front.sv
// ----------------------------------------------------------------------------
// i2cdw_front
// Input side: unpacks stream items and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module i2cdw_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cdw_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                                s_tuser,
    output logic                                q_valid,
    output i2cdw_pkg::item_t                    q_item,
    input  logic                                q_pop
);

    i2cdw_pkg::item_t slot_reg [2];
    i2cdw_pkg::item_t in_item;
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             push;
    logic             pop;

    // field unpack
    always_comb begin
        in_item.request = s_tdata[0];
        in_item.payload = s_tdata[8:1];
        in_item.sda_in  = s_tdata[9];
        in_item.op      = s_tuser;
    end

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_pop & q_valid;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    // queue pointers and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

>>> design/i2cdw_engine.sv
// ----------------------------------------------------------------------------
// i2cdw_engine
// Bus sequencer: one tick per queued item, result held in an output register.
// ----------------------------------------------------------------------------
module i2cdw_engine (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  i2cdw_pkg::cfg_t                     cfg,
    input  logic                                q_valid,
    input  i2cdw_pkg::item_t                    q_item,
    output logic                                q_pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2cdw_pkg::OUT_TDATA_W-1:0]   m_tdata
);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_START_A  = 4'd1,
        PH_START_B  = 4'd2,
        PH_BIT_LOW  = 4'd3,
        PH_BIT_HIGH = 4'd4,
        PH_ACK_LOW  = 4'd5,
        PH_ACK_HIGH = 4'd6,
        PH_STOP_A   = 4'd7,
        PH_STOP_B   = 4'd8,
        PH_STOP_C   = 4'd9
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  slot_reg, slot_next;
    logic [3:0]  bit_reg, bit_next;
    logic [15:0] tick_reg, tick_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  payload_reg, payload_next;
    logic        op_reg, op_next;
    logic [7:0]  ackw_reg, ackw_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic        err_reg, err_next;
    logic        done;

    logic [15:0] limit;
    logic [16:0] tick_inc;
    logic        tmo;
    logic [3:0]  bit_inc;
    logic [7:0]  shift_sh;
    logic [1:0]  slot_inc;
    logic [7:0]  next_byte;

    logic                           m_valid_reg;
    logic [i2cdw_pkg::OUT_TDATA_W-1:0] m_data_reg;
    logic                           step;
    logic                           drive;
    logic                           busy;

    // a tick runs when an item waits and the output register is free
    assign step     = q_valid & (~m_valid_reg | m_tready);
    assign q_pop    = step;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // phase timer: a zero length counts as one tick
    assign limit    = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
    assign tick_inc = {1'b0, tick_reg} + 17'd1;
    assign tmo      = (tick_inc >= {1'b0, limit});

    assign bit_inc   = bit_reg + 4'd1;
    assign shift_sh  = {shift_reg[6:0], 1'b0};
    assign slot_inc  = slot_reg + 2'd1;
    assign next_byte = (slot_inc == 2'd1)
                       ? (op_reg ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD)
                       : payload_reg;

    // next-state logic of the bus sequence
    always_comb begin
        phase_next   = phase_reg;
        slot_next    = slot_reg;
        bit_next     = bit_reg;
        tick_next    = tick_reg;
        shift_next   = shift_reg;
        payload_next = payload_reg;
        op_next      = op_reg;
        ackw_next    = ackw_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        err_next     = err_reg;
        done         = 1'b0;

        unique case (phase_reg)
            PH_IDLE: begin
                if (q_item.request) begin
                    payload_next = q_item.payload;
                    op_next      = q_item.op;
                    err_next     = 1'b0;
                    slot_next    = 2'd0;
                    bit_next     = 4'd0;
                    shift_next   = cfg.device_address;
                    tick_next    = 16'd0;
                    phase_next   = PH_START_A;
                    scl_next     = 1'b1;
                    sda_next     = 1'b0;
                end
            end
            PH_START_A: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    phase_next = PH_START_B;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end
            end
            PH_START_B: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    bit_next   = 4'd0;
                    phase_next = PH_BIT_LOW;
                    scl_next   = 1'b0;
                    sda_next   = shift_reg[7];
                end
            end
            PH_BIT_LOW: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    phase_next = PH_BIT_HIGH;
                    scl_next   = 1'b1;
                end
            end
            PH_BIT_HIGH: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    bit_next   = bit_inc;
                    shift_next = shift_sh;
                    scl_next   = 1'b0;
                    if (bit_inc >= 4'd8) begin
                        phase_next = PH_ACK_LOW;
                        sda_next   = 1'b1;
                    end else begin
                        phase_next = PH_BIT_LOW;
                        sda_next   = shift_sh[7];
                    end
                end
            end
            PH_ACK_LOW: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    phase_next = PH_ACK_HIGH;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                    ackw_next  = 8'd0;
                end
            end
            PH_ACK_HIGH: begin
                if (!q_item.sda_in) begin
                    tick_next = 16'd0;
                    if (slot_reg >= 2'd2) begin
                        phase_next = PH_STOP_A;
                        scl_next   = 1'b0;
                        sda_next   = 1'b0;
                    end else begin
                        slot_next  = slot_inc;
                        shift_next = next_byte;
                        bit_next   = 4'd0;
                        phase_next = PH_BIT_LOW;
                        scl_next   = 1'b0;
                        sda_next   = next_byte[7];
                    end
                end else if (ackw_reg >= cfg.ack_timeout) begin
                    // no ack in time: flag it and release the bus
                    err_next   = 1'b1;
                    tick_next  = 16'd0;
                    phase_next = PH_STOP_A;
                    scl_next   = 1'b0;
                    sda_next   = 1'b0;
                end else begin
                    ackw_next = ackw_reg + 8'd1;
                end
            end
            PH_STOP_A: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    phase_next = PH_STOP_B;
                    scl_next   = 1'b1;
                    sda_next   = 1'b0;
                end
            end
            PH_STOP_B: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    phase_next = PH_STOP_C;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
            end
            PH_STOP_C: begin
                tick_next = tmo ? 16'd0 : tick_inc[15:0];
                if (tmo) begin
                    done       = 1'b1;
                    phase_next = PH_IDLE;
                    scl_next   = 1'b1;
                    sda_next   = 1'b1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                tick_next  = 16'd0;
                scl_next   = 1'b1;
                sda_next   = 1'b1;
            end
        endcase
    end

    // result fields follow the state after this tick
    assign drive = (phase_next != PH_ACK_LOW) && (phase_next != PH_ACK_HIGH);
    assign busy  = (phase_next != PH_IDLE);

    // state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            slot_reg    <= 2'd0;
            bit_reg     <= 4'd0;
            tick_reg    <= 16'd0;
            shift_reg   <= 8'd0;
            payload_reg <= 8'd0;
            op_reg      <= 1'b0;
            ackw_reg    <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            err_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
        end else begin
            if (step) begin
                phase_reg   <= phase_next;
                slot_reg    <= slot_next;
                bit_reg     <= bit_next;
                tick_reg    <= tick_next;
                shift_reg   <= shift_next;
                payload_reg <= payload_next;
                op_reg      <= op_next;
                ackw_reg    <= ackw_next;
                scl_reg     <= scl_next;
                sda_reg     <= sda_next;
                err_reg     <= err_next;
                m_valid_reg <= 1'b1;
                m_data_reg  <= {2'b00, err_next, done, busy, drive, sda_next, scl_next};
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> design/i2c_display_write_engine_top.sv
// Path: an item passes the input queue, then the output register, to m_tdata.
// Throughput: one item per cycle unless the output stalls; one bus tick per item.
// A two-entry input queue and the output register let each side stall alone.
// Reset: aresetn is synchronous, active low; it empties the queue, drops
// m_tvalid, returns the sequencer to idle with both lines high and loads the
// register defaults.
// ----------------------------------------------------------------------------
// i2c_display_write_engine_top
// I2C three-byte write engine for a display controller, one tick per item.
// ----------------------------------------------------------------------------
module i2c_display_write_engine_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // request [0], payload [8:1], sda_in [9], zero [15:10]
    input  logic [i2cdw_pkg::IN_TDATA_W-1:0]   s_tdata,
    // op [0]
    input  logic                               s_tuser,
    // result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // scl [0], sda_out [1], sda_drive [2], busy_res [3], done_res [4],
    // nack_error [5], zero [7:6]
    output logic [i2cdw_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [i2cdw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [i2cdw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [i2cdw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                               pready
);

    i2cdw_pkg::cfg_t  cfg;
    i2cdw_pkg::item_t q_item;
    logic             q_valid;
    logic             q_pop;

    // register file
    i2cdw_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input queue
    i2cdw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // bus sequencer
    i2cdw_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // a queued item with a free output register is delivered next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && !m_tvalid) |=> m_tvalid)
        else $error("queued item not stepped");

    // end of a transaction leaves the bus idle with both lines high
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (!m_tdata[3] && m_tdata[0] && m_tdata[1]))
        else $error("done without idle bus");

    // a phase length write lands in the register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite && (paddr[3:2] == i2cdw_pkg::REG_PHASE_TICKS))
        |=> (cfg.phase_ticks == $past(pwdata[15:0])))
        else $error("phase length write lost");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C display write engine. Each input item is one
// bus tick; a cycle-accurate predictor of the bus sequencer runs on every
// accepted item and each result item is compared field by field. An acking
// display device is emulated from the predicted bus phase, with late, missing
// and exactly-on-limit acks, requests while busy and random line noise.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int MAX_REPORTS = 20;

    // bus sequencer phases
    typedef enum logic [3:0] {
        BP_IDLE     = 4'd0,
        BP_START_A  = 4'd1,
        BP_START_B  = 4'd2,
        BP_BIT_LOW  = 4'd3,
        BP_BIT_HIGH = 4'd4,
        BP_ACK_LOW  = 4'd5,
        BP_ACK_HIGH = 4'd6,
        BP_STOP_A   = 4'd7,
        BP_STOP_B   = 4'd8,
        BP_STOP_C   = 4'd9
    } bus_phase_t;

    // result item layout, lowest bit last
    typedef struct packed {
        logic nack_error;
        logic done_res;
        logic busy_res;
        logic sda_drive;
        logic sda_out;
        logic scl;
    } bus_result_t;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [i2cdw_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                              s_tuser;
    logic                              m_tvalid;
    logic                              m_tready = 1'b1;
    logic [i2cdw_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [i2cdw_pkg::APB_ADDR_W-1:0]  paddr;
    logic [i2cdw_pkg::APB_DATA_W-1:0]  pwdata;
    logic [i2cdw_pkg::APB_DATA_W-1:0]  prdata;
    logic                              pready;

    // predicted engine state and register copy
    i2cdw_pkg::cfg_t cfg = '{i2cdw_pkg::RST_PHASE_TICKS, i2cdw_pkg::RST_DEV_ADDR,
                             i2cdw_pkg::RST_ACK_TIMEOUT};
    bus_phase_t  bp = BP_IDLE;
    logic [1:0]  slot = '0;
    logic [3:0]  nbits = '0;
    logic [15:0] ticks = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  held_payload = '0;
    logic        held_op = 1'b0;
    logic [7:0]  ack_cnt = '0;
    logic        scl_q = 1'b1;
    logic        sda_q = 1'b1;
    logic        nack_q = 1'b0;

    bus_result_t expected_bus[$];

    int  err_count = 0;
    int  item_count = 0;
    int  xfer_count = 0;
    int  nack_count = 0;
    int  cycle_count = 0;
    int  hold_cnt = 0;
    bit  tx_gaps_on = 1'b1;
    bit  rx_stalls_on = 1'b1;

    i2c_display_write_engine_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // predictor of the bus sequencer
    // ------------------------------------------------------------------------

    // enter a phase and set the line levels it drives
    function automatic void go_phase(input bus_phase_t ph);
        bp    = ph;
        ticks = '0;
        case (ph)
            BP_START_A:  begin scl_q = 1'b1; sda_q = 1'b0; end
            BP_START_B:  begin scl_q = 1'b0; sda_q = 1'b0; end
            BP_BIT_LOW:  begin scl_q = 1'b0; sda_q = shreg[7]; end
            BP_BIT_HIGH: scl_q = 1'b1;
            BP_ACK_LOW:  begin scl_q = 1'b0; sda_q = 1'b1; end
            BP_ACK_HIGH: begin scl_q = 1'b1; sda_q = 1'b1; ack_cnt = '0; end
            BP_STOP_A:   begin scl_q = 1'b0; sda_q = 1'b0; end
            BP_STOP_B:   begin scl_q = 1'b1; sda_q = 1'b0; end
            BP_STOP_C:   begin scl_q = 1'b1; sda_q = 1'b1; end
            default:     begin bp = BP_IDLE; scl_q = 1'b1; sda_q = 1'b1; end
        endcase
    endfunction

    // level has been held for phase_ticks ticks; zero counts as one
    function automatic bit phase_elapsed();
        logic [16:0] lim;
        logic [16:0] nxt;
        lim = (cfg.phase_ticks == 16'd0) ? 17'd1 : {1'b0, cfg.phase_ticks};
        nxt = {1'b0, ticks} + 17'd1;
        if (nxt >= lim) begin
            ticks = '0;
            return 1'b1;
        end
        ticks = nxt[15:0];
        return 1'b0;
    endfunction

    // advance one tick and return the bus levels and flags after it
    function automatic bus_result_t predict_tick(input logic req, input logic op,
                                                 input logic [7:0] pay,
                                                 input logic sda_in);
        bus_result_t res;
        logic        done;
        done = 1'b0;
        case (bp)
            BP_IDLE: begin
                if (req) begin
                    held_payload = pay;
                    held_op      = op;
                    nack_q       = 1'b0;
                    slot         = '0;
                    nbits        = '0;
                    shreg        = cfg.device_address;
                    go_phase(BP_START_A);
                end
            end
            BP_START_A:  if (phase_elapsed()) go_phase(BP_START_B);
            BP_START_B: begin
                if (phase_elapsed()) begin
                    nbits = '0;
                    go_phase(BP_BIT_LOW);
                end
            end
            BP_BIT_LOW:  if (phase_elapsed()) go_phase(BP_BIT_HIGH);
            BP_BIT_HIGH: begin
                if (phase_elapsed()) begin
                    nbits = nbits + 4'd1;
                    shreg = {shreg[6:0], 1'b0};
                    if (nbits >= 4'd8) go_phase(BP_ACK_LOW);
                    else go_phase(BP_BIT_LOW);
                end
            end
            BP_ACK_LOW:  if (phase_elapsed()) go_phase(BP_ACK_HIGH);
            BP_ACK_HIGH: begin
                if (!sda_in) begin
                    if (slot >= 2'd2) begin
                        go_phase(BP_STOP_A);
                    end else begin
                        slot  = slot + 2'd1;
                        shreg = (slot == 2'd1)
                                ? (held_op ? i2cdw_pkg::CTRL_DATA : i2cdw_pkg::CTRL_CMD)
                                : held_payload;
                        nbits = '0;
                        go_phase(BP_BIT_LOW);
                    end
                end else if (ack_cnt >= cfg.ack_timeout) begin
                    // device never pulled SDA low: abort through a stop
                    nack_q = 1'b1;
                    nack_count++;
                    go_phase(BP_STOP_A);
                end else begin
                    ack_cnt = ack_cnt + 8'd1;
                end
            end
            BP_STOP_A:   if (phase_elapsed()) go_phase(BP_STOP_B);
            BP_STOP_B:   if (phase_elapsed()) go_phase(BP_STOP_C);
            BP_STOP_C: begin
                if (phase_elapsed()) begin
                    done = 1'b1;
                    xfer_count++;
                    go_phase(BP_IDLE);
                end
            end
            default:     go_phase(BP_IDLE);
        endcase
        res.scl        = scl_q;
        res.sda_out    = sda_q;
        res.sda_drive  = !(bp == BP_ACK_LOW || bp == BP_ACK_HIGH);
        res.busy_res   = (bp != BP_IDLE);
        res.done_res   = done;
        res.nack_error = nack_q;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checking and receiver back-pressure
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic want,
                                        input logic got);
        if (want !== got) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $realtime, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        bus_result_t got;
        bus_result_t want;
        int          r;
        if (aresetn && m_tvalid && m_tready) begin
            got = bus_result_t'(m_tdata[5:0]);
            if (expected_bus.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: result item with none expected, actual %02h",
                             $realtime, m_tdata);
            end else begin
                want = expected_bus.pop_front();
                check_field("scl", want.scl, got.scl);
                check_field("sda_out", want.sda_out, got.sda_out);
                check_field("sda_drive", want.sda_drive, got.sda_drive);
                check_field("busy_res", want.busy_res, got.busy_res);
                check_field("done_res", want.done_res, got.done_res);
                check_field("nack_error", want.nack_error, got.nack_error);
            end
        end
        // ready pattern: mostly high, short drops, an occasional long stall
        r = $urandom_range(0, 99);
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            m_tready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_tready <= 1'b1;
        end else if (r < 2) begin
            hold_cnt = $urandom_range(8, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= (r >= 22);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps_on || r < 75) return 0;
        if (r < 97) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // drive one tick item, wait for its acceptance, record its expected result
    task automatic send_tick(input logic req, input logic op, input logic [7:0] pay,
                             input logic sda_in);
        int gap;
        gap = pick_gap();
        if ($urandom_range(0, 199) == 0) begin
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, sda_in, pay, req};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        expected_bus.push_back(predict_tick(req, op, pay, sda_in));
        item_count++;
    endtask

    task automatic idle_tick();
        send_tick(1'b0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
    endtask

    // one transfer; the device acks each byte after the given number of high
    // samples, a delay past ack_timeout leaves the byte unacknowledged
    task automatic run_transfer(input logic op, input logic [7:0] pay,
                                input int dly_addr, input int dly_ctrl,
                                input int dly_data, input int busy_req_pct);
        int   dly;
        logic sda;
        send_tick(1'b1, op, pay, 1'($urandom_range(0, 1)));
        while (bp != BP_IDLE) begin
            if (bp == BP_ACK_HIGH) begin
                case (slot)
                    2'd0:    dly = dly_addr;
                    2'd1:    dly = dly_ctrl;
                    default: dly = dly_data;
                endcase
                sda = (int'(ack_cnt) >= dly) ? 1'b0 : 1'b1;
            end else begin
                sda = 1'($urandom_range(0, 1));
            end
            send_tick($urandom_range(0, 99) < busy_req_pct, 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), sda);
        end
    endtask

    function automatic int pick_ack_delay(input int lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(0, (lim < 3) ? lim : 3);
        if (r < 88) return lim;
        return lim + 1;
    endfunction

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_bus.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------

    task automatic read_reg(input logic [1:0] idx,
                            output logic [i2cdw_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        value = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(input logic [1:0] idx,
                             input logic [i2cdw_pkg::APB_DATA_W-1:0] want);
        logic [i2cdw_pkg::APB_DATA_W-1:0] got;
        read_reg(idx, got);
        if (got !== want) begin
            err_count++;
            if (err_count <= MAX_REPORTS)
                $display("%0t: register %0d readback, expected %0h, actual %0h",
                         $realtime, idx, want, got);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx,
                             input logic [i2cdw_pkg::APB_DATA_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            i2cdw_pkg::REG_PHASE_TICKS: cfg.phase_ticks    = value[15:0];
            i2cdw_pkg::REG_DEV_ADDR:    cfg.device_address = value[7:0];
            default:                    cfg.ack_timeout    = value[7:0];
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_reg(idx, value);
    endtask

    // engine must be idle with all results in before registers change
    task automatic set_cfg(input logic [15:0] phase, input logic [7:0] addr,
                           input logic [7:0] tmo);
        wait_drained();
        write_reg(i2cdw_pkg::REG_PHASE_TICKS, {16'd0, phase});
        write_reg(i2cdw_pkg::REG_DEV_ADDR, {24'd0, addr});
        write_reg(i2cdw_pkg::REG_ACK_TIMEOUT, {24'd0, tmo});
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_register_defaults();
        check_reg(i2cdw_pkg::REG_PHASE_TICKS, {16'd0, i2cdw_pkg::RST_PHASE_TICKS});
        check_reg(i2cdw_pkg::REG_DEV_ADDR, {24'd0, i2cdw_pkg::RST_DEV_ADDR});
        check_reg(i2cdw_pkg::REG_ACK_TIMEOUT, {24'd0, i2cdw_pkg::RST_ACK_TIMEOUT});
        send_tick(1'b0, 1'b1, 8'hFF, 1'b1);
        send_tick(1'b0, 1'b0, 8'h00, 1'b0);
        idle_tick();
    endtask

    // full transfer with the reset address and ack timeout, short hold time
    task automatic test_default_transfer();
        set_cfg(16'd2, i2cdw_pkg::RST_DEV_ADDR, i2cdw_pkg::RST_ACK_TIMEOUT);
        run_transfer(1'b1, 8'h3C, 0, 2, 0, 0);
    endtask

    // all-ones and all-zeros address and payload, ack on the last allowed sample
    task automatic test_field_extremes();
        set_cfg(16'd1, 8'hFF, 8'd1);
        run_transfer(1'b0, 8'h00, 0, 0, 0, 0);
        run_transfer(1'b1, 8'hFF, 1, 1, 1, 0);
        set_cfg(16'd1, 8'h00, 8'd1);
        run_transfer(1'b0, 8'hFF, 0, 1, 0, 0);
        run_transfer(1'b1, 8'hA5, 1, 0, 1, 0);
    endtask

    // no ack on each byte in turn, then a clean transfer clears the error
    task automatic test_missing_ack();
        set_cfg(16'd2, 8'h78, 8'd0);
        run_transfer(1'b0, 8'h5A, 1, 0, 0, 0);
        idle_tick();
        set_cfg(16'd1, 8'h3C, 8'd3);
        run_transfer(1'b1, 8'h81, 0, 4, 0, 0);
        run_transfer(1'b0, 8'h7E, 2, 3, 4, 0);
        idle_tick();
        run_transfer(1'b1, 8'hC3, 0, 0, 0, 0);
    endtask

    // longest ack wait, accepted on the last sample and then missed
    task automatic test_long_ack_wait();
        set_cfg(16'd1, 8'h78, 8'd255);
        run_transfer(1'b1, 8'h99, 255, 0, 256, 0);
    endtask

    // requests on every busy tick must be ignored
    task automatic test_request_while_busy();
        set_cfg(16'd3, 8'hA5, 8'd2);
        run_transfer(1'b0, 8'h42, 0, 1, 2, 100);
    endtask

    // zero hold time acts as one; the largest hold time only ticks while idle
    task automatic test_phase_length_extremes();
        set_cfg(16'd0, 8'h78, 8'd4);
        run_transfer(1'b1, 8'h5A, 0, 0, 0, 20);
        set_cfg(16'hFFFF, 8'h78, 8'd4);
        repeat (10) idle_tick();
    endtask

    task automatic test_random_traffic();
        int          stop_at;
        int          phase_end;
        int          r;
        logic [15:0] phase;
        logic [7:0]  tmo;
        stop_at = item_count + 400;
        while (item_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 60) phase = 16'($urandom_range(1, 2));
            else if (r < 85) phase = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'd3;
            else phase = 16'($urandom_range(4, 6));
            r = $urandom_range(0, 99);
            if (r < 50) tmo = 8'($urandom_range(0, 4));
            else if (r < 80) tmo = 8'($urandom_range(5, 20));
            else tmo = 8'($urandom_range(200, 255));
            set_cfg(phase, 8'($urandom_range(0, 255)), tmo);
            phase_end = item_count + $urandom_range(60, 150);
            while (item_count < phase_end && item_count < stop_at) begin
                repeat ($urandom_range(0, 4)) idle_tick();
                run_transfer(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                             pick_ack_delay(tmo), pick_ack_delay(tmo),
                             pick_ack_delay(tmo), 25);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_register_defaults();
        test_default_transfer();
        test_field_extremes();
        test_missing_ack();
        test_long_ack_wait();
        test_request_while_busy();
        test_phase_length_extremes();
        test_random_traffic();

        wait_drained();
        repeat (20) @(posedge aclk);
        if (expected_bus.size() != 0) err_count++;
        $display("covered %0d tick items, %0d stop conditions, %0d of them after no ack",
                 item_count, xfer_count, nack_count);
        $display("mismatches: %0d", err_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/i2cdw_pkg.sv
design/i2cdw_regs.sv
design/i2cdw_front.sv
design/i2cdw_engine.sv
design/i2c_display_write_engine_top.sv
tb/sv/testbench.sv
